@@ sv/bdsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsd_pkg
// shared widths and the controller to datapath command bundle
// ----------------------------------------------------------------------------
package bdsd_pkg;

    localparam int VALUE_W = 32;               // binary input width
    localparam int DIGITS  = 8;                // display positions converted
    localparam int DIGIT_W = 4;                // one bcd digit
    localparam int BCD_W   = DIGITS * DIGIT_W;
    localparam int CNT_W   = $clog2(VALUE_W);  // shift step counter

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;     // take a new value, clear the bcd accumulator
        logic shift;    // one add-3 and shift step
        logic publish;  // copy digits and enables to the output register
    } bdsd_cmd_t;

endpackage

@@ sv/bdsd_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsd_datapath
// shift-and-add-3 converter with output register and enable mask
// ----------------------------------------------------------------------------
module bdsd_datapath
    import bdsd_pkg::*;
(
    input  logic                             aclk,
    input  bdsd_cmd_t                        cmd,
    input  logic [VALUE_W-1:0]               value,
    output logic [DIGITS-1:0][DIGIT_W-1:0]   digits,
    output logic [DIGITS-1:0]                enable_n
);

    logic [VALUE_W-1:0]              bin_reg, bin_next;
    logic [BCD_W-1:0]                bcd_reg, bcd_next;
    logic                            ovf_reg, ovf_next;
    logic [DIGITS-1:0][DIGIT_W-1:0]  digits_reg;
    logic [DIGITS-1:0]               enable_n_reg;

    logic [BCD_W-1:0]                adj;
    logic [DIGITS-1:0]               lit;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        logic [DIGIT_W-1:0] d;
        for (int k = 0; k < DIGITS; k++) begin
            d = bcd_reg[k*DIGIT_W +: DIGIT_W];
            adj[k*DIGIT_W +: DIGIT_W] = (d >= DIGIT_W'(5)) ? d + DIGIT_W'(3) : d;
        end
    end

    // lit from the ones digit up to the top nonzero digit, all lit on overflow
    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int k = DIGITS - 1; k >= 0; k--) begin
            seen   = seen | (|bcd_reg[k*DIGIT_W +: DIGIT_W]);
            lit[k] = seen | ovf_reg | (k == 0);
        end
    end

    always_comb begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        ovf_next = ovf_reg;
        if (cmd.load) begin
            bin_next = value;
            bcd_next = '0;
            ovf_next = 1'b0;
        end else if (cmd.shift) begin
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_next = {adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            // a bit leaving the top digit means ten to the DIGITS or more
            ovf_next = ovf_reg | adj[BCD_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        ovf_reg <= ovf_next;
        if (cmd.publish) begin
            digits_reg   <= bcd_reg;
            enable_n_reg <= ~lit;
        end
    end

    assign digits   = digits_reg;
    assign enable_n = enable_n_reg;

endmodule

@@ sv/bdsd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsd_ctrl
// sequencer: accept, 32 conversion steps, hand over to the output register
// ----------------------------------------------------------------------------
module bdsd_ctrl
    import bdsd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output bdsd_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             mvalid_reg, mvalid_next;
    logic             out_free;

    // output register can take a new beat this cycle
    assign out_free = !mvalid_reg || m_tready;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(VALUE_W - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.publish = 1'b1;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;

endmodule

@@ sv/binary_to_decimal_segment_digits.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_segment_digits
// 32-bit binary to eight decimal digits with active-low display enables
// ----------------------------------------------------------------------------
// Each input beat carries a 32-bit unsigned value; one output beat follows
// with the eight decimal digits, ones digit lowest, and an active-low enable
// per position that lights the ones digit up to the most significant nonzero
// digit (zero shows a single 0). Values of 10^8 or more show their low eight
// digits with every position lit. Each value is accepted, then runs 32
// shift-and-add-3 steps (one per input bit, through a single step unit),
// then loads the output register once it is free. The output register lets
// the next value be accepted and converted while the previous result waits.
// ----------------------------------------------------------------------------
module binary_to_decimal_segment_digits
    import bdsd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [VALUE_W-1:0]     s_tdata,   // [31:0] value

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [3:0] digit_0, [7:4] digit_1, [11:8] digit_2, [15:12] digit_3,
    // [19:16] digit_4, [23:20] digit_5, [27:24] digit_6, [31:28] digit_7,
    // [39:32] enable_n
    output logic [39:0]            m_tdata
);

    bdsd_cmd_t                       cmd;
    logic [DIGITS-1:0][DIGIT_W-1:0]  digits;
    logic [DIGITS-1:0]               enable_n;

    // sequencer: handshakes and step count
    bdsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // conversion registers and output register
    bdsd_datapath u_datapath (
        .aclk     (aclk),
        .cmd      (cmd),
        .value    (s_tdata),
        .digits   (digits),
        .enable_n (enable_n)
    );

    // digits packed ones first, enables above them
    assign m_tdata = {enable_n, digits};

endmodule

@@ test/binary_to_decimal_segment_digits_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_segment_digits_tb
// self-checking bench for the binary to display digits converter
// ----------------------------------------------------------------------------
// Every accepted input beat is turned into an expected display beat by a
// behavioural divide-by-ten conversion and queued. Each output beat is then
// unpacked and compared digit by digit and on the enable mask against the
// oldest queued beat. Stimulus runs a directed set of edge values, a long
// random run spread over all digit counts, a long output hold-off that
// backs the block up, and a full drain pause. The sender idles in random
// bursts and the receiver stalls in changing patterns throughout.
// ----------------------------------------------------------------------------
module binary_to_decimal_segment_digits_tb;
    import bdsd_pkg::*;

    localparam int NUM_POS        = 8;     // digit fields on the output beat
    localparam int RANDOM_BEATS   = 1750;
    localparam int IDLE_LIMIT     = 5000;  // cycles with no beat moving
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int SETTLE_CYCLES  = 60;    // after the last result

    // output beat as laid out on m_tdata, digit 0 in the lowest nibble
    typedef struct packed {
        logic [7:0]                      enable_n;
        logic [NUM_POS-1:0][DIGIT_W-1:0] digit;
    } display_beat_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata;    // [31:0] value
    logic               m_tvalid;
    logic               m_tready;
    // [3:0] digit_0 .. [31:28] digit_7, [39:32] enable_n
    logic [39:0]        m_tdata;

    display_beat_t pending_displays[$];   // expected beats, oldest first
    display_beat_t want_display;
    display_beat_t got_display;
    int            mismatch_count = 0;
    int            idle_cycles    = 0;
    int            burst_left     = 0;    // beats left in the current burst
    bit            hold_pending   = 1'b0; // ask the receiver for a hold-off
    int            hold_left      = 0;
    int            stall_mode     = 0;
    int            mode_left      = 0;

    binary_to_decimal_segment_digits uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // expected display: repeated divide by ten, one position lit per digit,
    // zero still lights the ones position, anything past DIGITS is dropped
    function automatic display_beat_t decimal_display(input logic [VALUE_W-1:0] value);
        display_beat_t shown;
        int unsigned   rest;
        int            pos;
        shown          = '0;
        shown.enable_n = 8'hFF;
        rest           = value;
        pos            = 0;
        do begin
            if (pos < NUM_POS) begin
                shown.digit[pos]    = DIGIT_W'(rest % 10);
                shown.enable_n[pos] = 1'b0;
            end
            rest = rest / 10;
            pos++;
        end while (rest != 0 && pos < DIGITS);
        return shown;
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // offer one value; called at a falling edge, returns at a falling edge
    // after the beat was taken. tvalid is only dropped when a gap starts,
    // so back-to-back beats inside a burst keep it high
    task automatic send_value(input logic [VALUE_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            // a third of bursts follow on with no gap at all
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 50);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        burst_left--;
    endtask

    // stop offering and wait until every expected beat has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_displays.size() != 0) @(negedge aclk);
        burst_left = 0;
    endtask

    // ------------------------------------------------------------------
    // receiver side: stall pattern changes every so often, with a long
    // hold-off when asked for
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 128);
        end
        mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: begin
                    m_tready <= 1'b1;                          // always ready
                end
                1: begin
                    m_tready <= 1'($urandom_range(0, 1));      // coin toss
                end
                2: begin
                    m_tready <= ($urandom_range(0, 7) == 0);   // mostly stalled
                end
                default: begin
                    m_tready <= ~m_tready;                     // every other cycle
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // checker: queue a prediction for each input beat, compare each
    // output beat against the oldest one
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pending_displays.push_back(decimal_display(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got_display = display_beat_t'(m_tdata);
                if (pending_displays.size() == 0) begin
                    $display("%0t unexpected output beat %h", $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want_display = pending_displays.pop_front();
                    for (int p = 0; p < NUM_POS; p++) begin
                        if (got_display.digit[p] !== want_display.digit[p]) begin
                            $display("%0t digit_%0d expected %0d actual %0d", $time, p,
                                     want_display.digit[p], got_display.digit[p]);
                            mismatch_count++;
                        end
                    end
                    if (got_display.enable_n !== want_display.enable_n) begin
                        $display("%0t enable_n expected %b actual %b", $time,
                                 want_display.enable_n, got_display.enable_n);
                        mismatch_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    // watchdog: nothing moving for too long means the block has hung
    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("%0t no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // zero, digit count boundaries, truncation past eight digits, extremes
    task automatic test_directed_values();
        logic [VALUE_W-1:0] edge_values[$];
        edge_values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd1000,
                        32'd10000, 32'd100000, 32'd1000000, 32'd9999999,
                        32'd10000000, 32'd99999999, 32'd100000000, 32'd100000001,
                        32'd123456789, 32'd1000000000, 32'd4000000000,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                        32'hAAAA_AAAA, 32'h5555_5555};
        foreach (edge_values[i]) send_value(edge_values[i]);
        drain_results();
    endtask

    // random values, spread evenly over decimal lengths with some raw 32-bit
    task automatic test_random_values();
        longint             lo;
        longint             hi;
        int                 len;
        logic [VALUE_W-1:0] value;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if ($urandom_range(0, 3) == 0) begin
                value = $urandom;
            end else begin
                len = $urandom_range(1, 10);
                lo  = 1;
                for (int k = 1; k < len; k++) lo = lo * 10;
                hi  = lo * 10 - 1;
                if (len == 1) lo = 0;
                if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
                value = $urandom_range(int'(hi), int'(lo));
            end
            send_value(value);
        end
    endtask

    // long output hold-off while beats keep coming, so the input stalls
    task automatic test_output_hold_off();
        burst_left   = 40;
        hold_pending = 1'b1;
        for (int n = 0; n < 12; n++) send_value($urandom);
        drain_results();
    endtask

    // full drain pause between two short runs
    task automatic test_drain_pause();
        for (int n = 0; n < 10; n++) send_value($urandom_range(0, 99999));
        drain_results();
        for (int n = 0; n < 10; n++) send_value($urandom);
        drain_results();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_values();
        test_output_hold_off();
        test_random_values();
        test_drain_pause();

        // everything offered has been taken; let the results come home
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/bdsd_pkg.sv
sv/bdsd_datapath.sv
sv/bdsd_ctrl.sv
sv/binary_to_decimal_segment_digits.sv
test/binary_to_decimal_segment_digits_tb.sv
